// File: sv/dea_pkg.sv
// Shared types and constants for the depth edge antialias block.
// No dependencies; imported by the top level and its port checker.
package dea_pkg;

    // Default sizing of the datapath
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int DEPTH_BITS_DEF   = 24;
    localparam int MAX_HEIGHT       = 4096;

    // Port field widths
    localparam int CH_W        = 16;
    localparam int DEPTH_W     = 24;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 12;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register widths and reset values
    localparam int FW_W  = 12;
    localparam int FH_W  = 13;
    localparam int LIM_W = 16;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = FH_W'(480);
    localparam logic [LIM_W-1:0] RATIO_LIMIT_RST  = LIM_W'(269);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_RATIO_LIMIT  = 2'd2
    } cfg_reg_t;

    // One emitted pixel, packed as it leaves on the master side
    typedef struct packed {
        logic             blended;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } res_t;

endpackage

// File: sv/depth_edge_antialias_top.sv
// Depth edge antialias: 2x2 depth-discontinuity blend on a raster pixel stream.
// A result passes stages 1 to 3 and the result queue before it shows on m_tvalid.
// Throughput: one item per cycle while m_tready is high; an item with two or three
// results (last column, last row) holds s_tready low until its final one is handed out.
// Reset (rst_n, async, active low) clears pipeline valids, the result queue,
// the counters and the registers to defaults; the line buffer is not cleared.
//
// Depends on dea_pkg.
module depth_edge_antialias_top #(
    parameter int MAX_WIDTH    = dea_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = dea_pkg::CHANNEL_BITS_DEF,
    parameter int DEPTH_BITS   = dea_pkg::DEPTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side: red, green, blue, depth (from bit 0 up)
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dea_pkg::IN_TDATA_W-1:0]   s_tdata,
    // master side: col, row, out_red, out_green, out_blue, one zero pad bit
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dea_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // blended
    output logic                             m_tuser,
    // last
    output logic                             m_tlast,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dea_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dea_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dea_pkg::*;

    localparam int CB   = CHANNEL_BITS;
    localparam int DB   = DEPTH_BITS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int NP   = 5;          // depth pairs tested per window
    localparam int PRDW = DB + LIM_W; // limit * smaller depth

    // Result slots in emission order
    localparam int SLOT_WIN = 0;      // window result for the top-left pixel
    localparam int SLOT_UP  = 1;      // last column, pixel of the row above
    localparam int SLOT_CUR = 2;      // last row, incoming pixel

    typedef struct packed {
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        logic [DB-1:0] d;
    } pix_t;

    // ------------------------------------------------------------------
    // Configuration registers and raster position
    // ------------------------------------------------------------------
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [LIM_W-1:0] ratio_limit_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [31:0]      wl_full, hl_full;
    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic             cfg_wr, geom_wr, s_acc, adv;
    logic [2:0]       flags_in;
    pix_t             cur_in;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom_wr   = cfg_wr && ((cfg_index == REG_FRAME_WIDTH) ||
                                  (cfg_index == REG_FRAME_HEIGHT));

    // Clamp the geometry registers: zero reads as one, oversize as the maximum.
    always_comb
    begin
        if (frame_width_reg == '0)
            wl_full = '0;
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            wl_full = 32'(MAX_WIDTH - 1);
        else
            wl_full = 32'(frame_width_reg) - 32'd1;

        if (frame_height_reg == '0)
            hl_full = '0;
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            hl_full = 32'(MAX_HEIGHT - 1);
        else
            hl_full = 32'(frame_height_reg) - 32'd1;
    end

    assign w_last = wl_full[CW-1:0];
    assign h_last = hl_full[ROW_W-1:0];

    // Step to the next raster position, wrapping at the end of the frame.
    always_comb
    begin
        if (col_reg == w_last)
        begin
            col_next = '0;
            row_next = (row_reg == h_last) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    // Which results this item will produce
    assign flags_in[SLOT_WIN] = (row_reg != '0) && (col_reg != '0);
    assign flags_in[SLOT_UP]  = (row_reg != '0) && (col_reg == w_last);
    assign flags_in[SLOT_CUR] = (row_reg == h_last);

    // Unpack the slave item, keeping only the configured channel and depth bits
    assign cur_in.r = CB'(s_tdata[0 +: CH_W]);
    assign cur_in.g = CB'(s_tdata[CH_W +: CH_W]);
    assign cur_in.b = CB'(s_tdata[2*CH_W +: CH_W]);
    assign cur_in.d = DB'(s_tdata[3*CH_W +: DEPTH_W]);

    // ------------------------------------------------------------------
    // Pipeline: accept/line-buffer read -> depth pair order -> products
    // and color sums -> result queue. All stages move together on adv.
    // ------------------------------------------------------------------
    logic [2:0]       mask_reg;
    res_t             res_reg [3];

    // The pipeline moves whenever the result queue is empty or hands out
    // its final entry in this cycle.
    assign adv      = (mask_reg == '0) ||
                      (m_tready && ((mask_reg & (mask_reg - 3'd1)) == '0));
    assign s_tready = adv;
    assign s_acc    = s_tvalid && s_tready;

    // Line buffer: holds the previous row; read the old entry and overwrite it
    // with the incoming pixel in the same cycle.
    logic [$bits(pix_t)-1:0] line_mem [MAX_WIDTH];

    // Stage 1
    logic             v1_reg;
    pix_t             cur1_reg, up1_reg;
    logic [CW-1:0]    col1_reg;
    logic [ROW_W-1:0] row1_reg;
    logic [2:0]       flags1_reg;

    // Window history: pixels of the previous item (upper-left and left)
    pix_t             ul_reg, left_reg;

    // Stage 2
    logic             v2_reg;
    pix_t             tl2_reg, tr2_reg, bl2_reg, br2_reg;
    logic [DB-1:0]    hi2_reg [NP];
    logic [DB-1:0]    lo2_reg [NP];
    logic [CW-1:0]    col2_reg;
    logic [ROW_W-1:0] row2_reg;
    logic [2:0]       flags2_reg;
    logic [DB-1:0]    pa [NP];
    logic [DB-1:0]    pb [NP];

    // Stage 3
    logic             v3_reg;
    pix_t             tl3_reg, up3_reg, cur3_reg;
    logic [CB+1:0]    sum_r3_reg, sum_g3_reg, sum_b3_reg;
    logic [DB-1:0]    hi3_reg  [NP];
    logic [PRDW-1:0]  prod3_reg [NP];
    logic [CW-1:0]    col3_reg;
    logic [ROW_W-1:0] row3_reg;
    logic [2:0]       flags3_reg;

    // Result formation
    logic          edge_hit;
    res_t          win_res, up_res, cur_res;
    logic [31:0]   col_w, row_w;

    // Depth pairs: TL-BL, TL-BR, TL-TR, BL-TR, BL-BR
    always_comb
    begin
        pa[0] = ul_reg.d;   pb[0] = left_reg.d;
        pa[1] = ul_reg.d;   pb[1] = cur1_reg.d;
        pa[2] = ul_reg.d;   pb[2] = up1_reg.d;
        pa[3] = left_reg.d; pb[3] = up1_reg.d;
        pa[4] = left_reg.d; pb[4] = cur1_reg.d;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            ratio_limit_reg  <= RATIO_LIMIT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            mask_reg         <= '0;
            ul_reg           <= '0;
            left_reg         <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    REG_RATIO_LIMIT:  ratio_limit_reg  <= cfg_data[LIM_W-1:0];
                    default: ;  // unknown index: drop the write
                endcase
            end

            // A geometry write restarts the frame at the top-left corner.
            if (geom_wr)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (s_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (adv)
            begin
                v1_reg <= s_acc;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                if (v1_reg)
                begin
                    ul_reg   <= up1_reg;
                    left_reg <= cur1_reg;
                end
            end

            // Load a new set of results, or retire the one just taken.
            if (adv)
                mask_reg <= v3_reg ? flags3_reg : '0;
            else if (m_tvalid && m_tready)
                mask_reg <= mask_reg & (mask_reg - 3'd1);
        end
    end

    // Line buffer access
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            up1_reg           <= line_mem[col_reg];
            line_mem[col_reg] <= cur_in;
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cur1_reg   <= cur_in;
            col1_reg   <= col_reg;
            row1_reg   <= row_reg;
            flags1_reg <= flags_in;
        end

        if (adv)
        begin
            // Stage 2: order each depth pair into larger and smaller
            tl2_reg    <= ul_reg;
            bl2_reg    <= left_reg;
            tr2_reg    <= up1_reg;
            br2_reg    <= cur1_reg;
            col2_reg   <= col1_reg;
            row2_reg   <= row1_reg;
            flags2_reg <= flags1_reg;
            for (int i = 0; i < NP; i++)
            begin
                hi2_reg[i] <= (pa[i] > pb[i]) ? pa[i] : pb[i];
                lo2_reg[i] <= (pa[i] > pb[i]) ? pb[i] : pa[i];
            end

            // Stage 3: scale the smaller depth by the limit, sum the colors
            for (int i = 0; i < NP; i++)
            begin
                hi3_reg[i]   <= hi2_reg[i];
                prod3_reg[i] <= PRDW'(ratio_limit_reg) * PRDW'(lo2_reg[i]);
            end
            sum_r3_reg <= (CB+2)'(tl2_reg.r) + (CB+2)'(tr2_reg.r)
                        + (CB+2)'(bl2_reg.r) + (CB+2)'(br2_reg.r);
            sum_g3_reg <= (CB+2)'(tl2_reg.g) + (CB+2)'(tr2_reg.g)
                        + (CB+2)'(bl2_reg.g) + (CB+2)'(br2_reg.g);
            sum_b3_reg <= (CB+2)'(tl2_reg.b) + (CB+2)'(tr2_reg.b)
                        + (CB+2)'(bl2_reg.b) + (CB+2)'(br2_reg.b);
            tl3_reg    <= tl2_reg;
            up3_reg    <= tr2_reg;
            cur3_reg   <= br2_reg;
            col3_reg   <= col2_reg;
            row3_reg   <= row2_reg;
            flags3_reg <= flags2_reg;
        end

        if (adv && v3_reg)
        begin
            res_reg[SLOT_WIN] <= win_res;
            res_reg[SLOT_UP]  <= up_res;
            res_reg[SLOT_CUR] <= cur_res;
        end
    end

    // ------------------------------------------------------------------
    // Result formation at the queue input
    // ------------------------------------------------------------------
    always_comb
    begin
        // A pair counts when larger * 256 > limit * smaller.
        edge_hit = 1'b0;
        for (int i = 0; i < NP; i++)
            edge_hit = edge_hit ||
                       ((PRDW'({hi3_reg[i], 8'h00})) > prod3_reg[i]);

        col_w = 32'(col3_reg);
        row_w = 32'(row3_reg);

        win_res.col     = COL_W'(col_w - 32'd1);
        win_res.row     = ROW_W'(row_w - 32'd1);
        win_res.blended = edge_hit;
        if (edge_hit)
        begin
            win_res.red   = CH_W'(sum_r3_reg[CB+1:2]);
            win_res.green = CH_W'(sum_g3_reg[CB+1:2]);
            win_res.blue  = CH_W'(sum_b3_reg[CB+1:2]);
        end
        else
        begin
            win_res.red   = CH_W'(tl3_reg.r);
            win_res.green = CH_W'(tl3_reg.g);
            win_res.blue  = CH_W'(tl3_reg.b);
        end

        up_res.col     = COL_W'(col_w);
        up_res.row     = ROW_W'(row_w - 32'd1);
        up_res.red     = CH_W'(up3_reg.r);
        up_res.green   = CH_W'(up3_reg.g);
        up_res.blue    = CH_W'(up3_reg.b);
        up_res.blended = 1'b0;

        cur_res.col     = COL_W'(col_w);
        cur_res.row     = ROW_W'(row_w);
        cur_res.red     = CH_W'(cur3_reg.r);
        cur_res.green   = CH_W'(cur3_reg.g);
        cur_res.blue    = CH_W'(cur3_reg.b);
        cur_res.blended = 1'b0;
    end

    // ------------------------------------------------------------------
    // Output: hand out the lowest pending slot; the item is last when no
    // other slot is pending.
    // ------------------------------------------------------------------
    res_t sel_res;

    always_comb
    begin
        priority if (mask_reg[SLOT_WIN])
            sel_res = res_reg[SLOT_WIN];
        else if (mask_reg[SLOT_UP])
            sel_res = res_reg[SLOT_UP];
        else
            sel_res = res_reg[SLOT_CUR];
    end

    assign m_tvalid = (mask_reg != '0);
    assign m_tlast  = ((mask_reg & (mask_reg - 3'd1)) == '0);
    assign m_tuser  = sel_res.blended;
    assign m_tdata  = {1'b0, sel_res.blue, sel_res.green, sel_res.red,
                       sel_res.row, sel_res.col};

endmodule

// File: sv/dea_checker.sv
// Port-level checks for depth_edge_antialias_top, attached by bind below.
// Depends on dea_pkg.
module dea_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dea_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);
    import dea_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Input is held off only while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // The rest of an item's results follow without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an item's results");

    // The pad bit above the blue channel stays clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1] == 1'b0))
        else $error("pad bit set");

endmodule

bind depth_edge_antialias_top dea_checker u_dea_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for depth_edge_antialias_top: a 2x2 depth-edge blend on a pixel stream.
// Needs dea_pkg and the top level only; a built-in predictor or send_pixel supplies every expected pixel.
module testbench;

    import dea_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 3;
    // Allow for items still in flight in the pipeline that produce no result (row 0 of a frame).
    localparam int SETTLE_CYCLES = 8;
    // Longest legal stretch with no item moving is the receiver's long hold.
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 200;
    // Random items sent before the receiver takes its long hold
    localparam int SQUEEZE_AFTER = 80;

    // Register index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Bit positions of the result fields in m_tdata
    localparam int ROW_LSB   = COL_W;
    localparam int RED_LSB   = COL_W + ROW_W;
    localparam int GREEN_LSB = RED_LSB + CH_W;
    localparam int BLUE_LSB  = GREEN_LSB + CH_W;

    // How a directed row is checked
    localparam int EXP_PREDICT = -1;  // expectation from the predictor
    localparam int EXP_NONE    = 0;   // the item must not produce a result
    localparam int EXP_ORIGIN  = 1;   // 1x1 frame: the item comes back unchanged at (0,0)

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    // Packed so that it drops straight onto s_tdata: red in the low bits.
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    red;
    } pixel_t;

    typedef struct packed {
        logic             last;
        logic             blended;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } emit_t;

    typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        pixel_t                 px;
        int                     typed;
    } script_step_t;

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;    // red, green, blue, depth (from bit 0 up)
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;    // col, row, out_red, out_green, out_blue, zero pad
    logic                    m_tuser;    // blended
    logic                    m_tlast;    // last
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    depth_edge_antialias_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: registers, raster position, line buffer and window
    // ------------------------------------------------------------------
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [LIM_W-1:0] limit_reg;
    int               col_pos;
    int               row_pos;
    pixel_t           line_mem [MAX_WIDTH_DEF];
    pixel_t           left_px;
    pixel_t           upleft_px;

    // Pixels the block still owes us, oldest first
    emit_t            expected_px [$];

    // Run bookkeeping
    int               mismatches = 0;
    int               pixels_sent = 0;
    int               regs_written = 0;
    int               results_checked = 0;
    int               blends_seen = 0;
    int               burst_left = 0;
    int               idle_cycles = 0;
    logic             squeeze_out;  // asks the receiver for its one long hold

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // A depth pair is an edge when larger/smaller exceeds the Q8.8 limit.
    // Exactly one zero depth always counts, two zeros never do.
    function automatic bit ratio_exceeds(input logic [DEPTH_W-1:0] a, input logic [DEPTH_W-1:0] b);
        logic [DEPTH_W-1:0] hi;
        logic [DEPTH_W-1:0] lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return 40'({hi, 8'h00}) > 40'(limit_reg) * 40'(lo);
    endfunction

    // Truncated mean of four channel values
    function automatic logic [CH_W-1:0] avg4(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                             input logic [CH_W-1:0] c, input logic [CH_W-1:0] d);
        logic [CH_W+1:0] sum;
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return sum[CH_W+1:2];
    endfunction

    function automatic emit_t make_emit(input int c, input int r, input pixel_t p, input bit mixed);
        emit_t e;
        e.col     = COL_W'(c);
        e.row     = ROW_W'(r);
        e.red     = p.red;
        e.green   = p.green;
        e.blue    = p.blue;
        e.blended = mixed;
        e.last    = 1'b0;
        return e;
    endfunction

    // Advance the raster by one pixel and return the pixels it releases:
    // the finished window at (c-1,r-1), the last column of the row above,
    // and the pixel itself when it sits in the last row.
    task automatic predict_pixel(input pixel_t cur, output emit_t outs [3], output int n);
        int     w;
        int     h;
        int     c;
        int     r;
        pixel_t up;
        pixel_t mix;
        bit     hit;
        w = (width_reg == '0) ? 1 :
            ((int'(width_reg) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg));
        h = (height_reg == '0) ? 1 :
            ((int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        n = 0;
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        c  = col_pos;
        r  = row_pos;
        up = line_mem[c];
        if (r >= 1 && c >= 1)
        begin
            // corners: TL = upleft_px, TR = up, BL = left_px, BR = cur
            hit = ratio_exceeds(upleft_px.depth, left_px.depth) ||
                  ratio_exceeds(upleft_px.depth, cur.depth) ||
                  ratio_exceeds(upleft_px.depth, up.depth) ||
                  ratio_exceeds(left_px.depth, up.depth) ||
                  ratio_exceeds(left_px.depth, cur.depth);
            mix = upleft_px;
            if (hit)
            begin
                mix.red   = avg4(upleft_px.red, up.red, left_px.red, cur.red);
                mix.green = avg4(upleft_px.green, up.green, left_px.green, cur.green);
                mix.blue  = avg4(upleft_px.blue, up.blue, left_px.blue, cur.blue);
            end
            outs[n] = make_emit(c - 1, r - 1, mix, hit);
            n++;
        end
        if (r >= 1 && c == w - 1)
        begin
            outs[n] = make_emit(c, r - 1, up, 1'b0);
            n++;
        end
        if (r == h - 1)
        begin
            outs[n] = make_emit(c, r, cur, 1'b0);
            n++;
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        upleft_px   = up;
        left_px     = cur;
        line_mem[c] = cur;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Drop the input valid, wait for every owed pixel, then let the pipeline empty.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register on an idle block and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        regs_written++;
        // geometry writes restart the frame at the origin
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_reg = val[FW_W-1:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg = val[FH_W-1:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            REG_RATIO_LIMIT:
                limit_reg = val;
            default: ;
        endcase
    endtask

    // Offer one pixel in burst/gap rhythm, hold it until taken, then log what it owes.
    task automatic send_pixel(input pixel_t p, input int typed);
        emit_t outs [3];
        emit_t solo;
        int    n;
        int    gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
        predict_pixel(p, outs, n);
        if (typed == EXP_PREDICT)
        begin
            for (int k = 0; k < n; k++)
                expected_px.push_back(outs[k]);
        end
        else if (typed == EXP_ORIGIN)
        begin
            solo         = '0;
            solo.red     = p.red;
            solo.green   = p.green;
            solo.blue    = p.blue;
            solo.last    = 1'b1;
            expected_px.push_back(solo);
        end
    endtask

    // Random colour; depth mostly near a base so that the ratio test lands on
    // both sides of the limit, with zeros and full-range values mixed in.
    function automatic pixel_t draw_pixel(input int unsigned base);
        pixel_t      p;
        int unsigned k;
        p.red   = CH_W'($urandom());
        p.green = CH_W'($urandom());
        p.blue  = CH_W'($urandom());
        k = $urandom_range(0, 9);
        if (k == 0)
            p.depth = '0;
        else if (k == 1)
            p.depth = DEPTH_W'($urandom());
        else
            p.depth = DEPTH_W'(base + $urandom_range(0, base / 8 + 1));
        return p;
    endfunction

    function automatic script_step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] val);
        script_step_t s;
        s.kind    = STEP_CFG;
        s.reg_idx = idx;
        s.reg_val = val;
        s.px      = '0;
        s.typed   = EXP_PREDICT;
        return s;
    endfunction

    function automatic script_step_t px_step(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                             input logic [CH_W-1:0] b,
                                             input logic [DEPTH_W-1:0] d, input int typed);
        script_step_t s;
        s.kind     = STEP_PIXEL;
        s.reg_idx  = '0;
        s.reg_val  = '0;
        s.px.red   = r;
        s.px.green = g;
        s.px.blue  = b;
        s.px.depth = d;
        s.typed    = typed;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random frames with one long output hold
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        script_step_t script [$];
        int           rand_items;
        int           n;
        int unsigned  base;
        logic [CFG_DATA_W-1:0] lim;

        // drive every input to a known value from time zero
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        squeeze_out <= 1'b0;

        // predictor starts from the reset defaults
        width_reg  = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        limit_reg  = RATIO_LIMIT_RST;
        col_pos    = 0;
        row_pos    = 0;
        left_px    = '0;
        upleft_px  = '0;
        foreach (line_mem[i])
            line_mem[i] = '0;

        // Directed table. After reset the frame is 640x480, so row 0 is silent.
        script.push_back(px_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, EXP_NONE));
        script.push_back(px_step(16'h0000, 16'h0000, 16'h0000, 24'h000000, EXP_NONE));
        // zero width and height are taken as 1: every pixel comes straight back
        script.push_back(reg_step(REG_FRAME_WIDTH, 16'h0000));
        script.push_back(reg_step(REG_FRAME_HEIGHT, 16'h0000));
        script.push_back(px_step(16'hFFFF, 16'h0000, 16'hFFFF, 24'hFFFFFF, EXP_ORIGIN));
        script.push_back(px_step(16'h0000, 16'hFFFF, 16'h0000, 24'h000000, EXP_ORIGIN));
        // 2x2 frames: the last pixel releases window, last column and itself
        script.push_back(reg_step(REG_FRAME_WIDTH, 16'd2));
        script.push_back(reg_step(REG_FRAME_HEIGHT, 16'd2));
        script.push_back(reg_step(REG_RATIO_LIMIT, 16'd0));
        // all depths zero: no pair counts even at the lowest limit
        script.push_back(px_step(16'h1000, 16'h2000, 16'h3000, 24'd0, EXP_PREDICT));
        script.push_back(px_step(16'h1100, 16'h2100, 16'h3100, 24'd0, EXP_PREDICT));
        script.push_back(px_step(16'h1200, 16'h2200, 16'h3200, 24'd0, EXP_PREDICT));
        script.push_back(px_step(16'h1300, 16'h2300, 16'h3300, 24'd0, EXP_PREDICT));
        // one zero against a nonzero depth counts; sums chosen to show truncation
        script.push_back(px_step(16'h0001, 16'h0003, 16'hFFFF, 24'd0, EXP_PREDICT));
        script.push_back(px_step(16'h0002, 16'h0003, 16'hFFFE, 24'd0, EXP_PREDICT));
        script.push_back(px_step(16'h0003, 16'h0003, 16'hFFFD, 24'd0, EXP_PREDICT));
        script.push_back(px_step(16'h0005, 16'h0004, 16'hFFFC, 24'd9, EXP_PREDICT));
        // top limit: only a ratio above 255.99 or a lone zero counts
        script.push_back(reg_step(REG_RATIO_LIMIT, 16'hFFFF));
        script.push_back(px_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd1, EXP_PREDICT));
        script.push_back(px_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd300, EXP_PREDICT));
        script.push_back(px_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd1, EXP_PREDICT));
        script.push_back(px_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd1, EXP_PREDICT));
        // equal maximum depths pass; a write to the unused index must not restart
        script.push_back(px_step(16'hA5A5, 16'h5A5A, 16'h0F0F, 24'hFFFFFF, EXP_PREDICT));
        script.push_back(px_step(16'h5A5A, 16'hA5A5, 16'hF0F0, 24'hFFFFFF, EXP_PREDICT));
        script.push_back(reg_step(REG_SPARE, 16'hFFFF));
        script.push_back(px_step(16'h0F0F, 16'hF0F0, 16'hA5A5, 24'hFFFFFF, EXP_PREDICT));
        script.push_back(px_step(16'hF0F0, 16'h0F0F, 16'h5A5A, 24'hFFFFFF, EXP_PREDICT));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == STEP_CFG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_pixel(script[i].px, script[i].typed);
        end

        // Random frames: small geometry, varied limits, partial frames allowed.
        // Partway through, hold the output off while pixels keep coming.
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (rand_items == 0 || $urandom_range(0, 3) != 0)
            begin
                write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 7)));
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 5)));
            end
            case ($urandom_range(0, 5))
                0:       lim = '0;
                1:       lim = '1;
                2:       lim = CFG_DATA_W'(256);
                3:       lim = RATIO_LIMIT_RST;
                4:       lim = CFG_DATA_W'($urandom_range(256, 640));
                default: lim = CFG_DATA_W'($urandom());
            endcase
            write_reg(REG_RATIO_LIMIT, lim);
            base = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24'hE00000)
                                               : $urandom_range(1, 2000);
            n = $urandom_range(8, 40);
            if (!squeeze_out && rand_items >= SQUEEZE_AFTER)
                squeeze_out <= 1'b1;
            repeat (n) send_pixel(draw_pixel(base), EXP_PREDICT);
            rand_items += n;
        end

        settle_block();
        $display("Sent %0d pixels (%0d random) across %0d register writes, one long output hold.",
                 pixels_sent, rand_items, regs_written);
        $display("Compared %0d output pixels, %0d of them blended.", results_checked, blends_seen);
        if (mismatches == 0 && expected_px.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: cycles through ready patterns, plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned cyc;
        int unsigned hold_left;
        bit          held;
        cyc       = 0;
        hold_left = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (squeeze_out && !held)
            begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                // hold off long enough for the block to back up into s_tready
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case ((cyc >> 7) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= (cyc % 3 != 0);
                    default: m_tready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted output pixel against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        emit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (expected_px.size() == 0)
            begin
                mismatches++;
                $error("unexpected output pixel at col %0d row %0d",
                       m_tdata[COL_W-1:0], m_tdata[ROW_LSB +: ROW_W]);
            end
            else
            begin
                want = expected_px.pop_front();
                if (want.blended)
                    blends_seen++;
                check_field("col", 32'(want.col), 32'(m_tdata[COL_W-1:0]));
                check_field("row", 32'(want.row), 32'(m_tdata[ROW_LSB +: ROW_W]));
                check_field("out_red", 32'(want.red), 32'(m_tdata[RED_LSB +: CH_W]));
                check_field("out_green", 32'(want.green), 32'(m_tdata[GREEN_LSB +: CH_W]));
                check_field("out_blue", 32'(want.blue), 32'(m_tdata[BLUE_LSB +: CH_W]));
                check_field("pad", 32'(0), 32'(m_tdata[OUT_TDATA_W-1]));
                check_field("blended", 32'(want.blended), 32'(m_tuser));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no item moves on any channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles, %0d output pixels still owed.",
                     idle_cycles, expected_px.size());
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: filelist.f
sv/dea_pkg.sv
sv/depth_edge_antialias_top.sv
sv/dea_checker.sv
bench/testbench.sv
